// File: hdl/m4m_pkg.sv
package m4m_pkg;

  // Width of one matrix element and of one exact product.
  localparam int ELEM_W = 32;
  localparam int PROD_W = 2 * ELEM_W;

  // Width of the element position field on the ports.
  localparam int INDEX_W = 4;

  // Number of command words the queue between front and back can hold.
  localparam int QUEUE_DEPTH = 2;

  // Saturation limits of a Q16.16 result word.
  localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  // One command word: an optional store write and an optional start.
  typedef struct packed {
    logic               wr;
    logic [INDEX_W-1:0] idx;
    logic [ELEM_W-1:0]  a;
    logic [ELEM_W-1:0]  b;
    logic               start;
  } cmd_t;

  // Status of the command queue as seen by its neighbors.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  // One result word of the product matrix.
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [ELEM_W-1:0]  value;
    logic               saturated;
    logic               last;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_DRAIN,
    BK_EMIT
  } back_state_e;

endpackage

// File: hdl/matrix4x4_multiply_top.sv
// Square matrix multiplier for signed Q16.16 elements in column-major order.
// Each input word writes one element of A and the element of B at the same
// position; a position beyond the matrix writes nothing. A word with
// start_req_i set asks for C = A * B after its own write, and the block then
// delivers all MATRIX_DIM * MATRIX_DIM elements of C in column-major order,
// the final one flagged by out_last_o. Each element is the exact sum of its
// products, with FRAC_BITS fraction bits dropped toward minus infinity and
// clipped to the signed 32-bit range; saturated_o marks a clipped element.
// Both stores read as zero after reset. Input words pass through a two-word
// command queue, so the input is taken every cycle while the queue has room;
// a plain write leaves the queue as soon as the back end is idle. Each product
// element is built by one multiply-accumulate per cycle on a single 32 by 32
// multiplier, through store read, multiply, accumulate and output register;
// a full result has 16 elements at the default size and is held back
// whenever the output stalls. While a product is being emitted up to two
// further words wait in the queue, after which the input stalls until the
// back end takes the next queued word, in the cycle after the last element
// has been loaded into the output register.
module matrix4x4_multiply_top #(
  parameter int MATRIX_DIM = 4,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [m4m_pkg::INDEX_W-1:0]         elem_index_i,
  input  logic signed [m4m_pkg::ELEM_W-1:0]   a_elem_i,
  input  logic signed [m4m_pkg::ELEM_W-1:0]   b_elem_i,
  input  logic                                start_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [m4m_pkg::INDEX_W-1:0]         out_index_o,
  output logic signed [m4m_pkg::ELEM_W-1:0]   out_value_o,
  output logic                                saturated_o,
  output logic                                out_last_o
);

  // Front and back exchange command words through the queue.
  m4m_pkg::cmd_t          push_cmd, head_cmd;
  m4m_pkg::queue_status_t q_status;
  m4m_pkg::result_t       result;
  logic                   push, pop;

  m4m_front #(
    .MATRIX_DIM(MATRIX_DIM)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .elem_index_i(elem_index_i),
    .a_elem_i    (a_elem_i),
    .b_elem_i    (b_elem_i),
    .start_req_i (start_req_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  m4m_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .status_o(q_status)
  );

  // The back end owns both stores, so a write queued behind a start is
  // applied only after every element of that product has been computed.
  m4m_back #(
    .MATRIX_DIM(MATRIX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (head_cmd),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_o   (result)
  );

  assign out_index_o = result.index;
  assign out_value_o = result.value;
  assign saturated_o = result.saturated;
  assign out_last_o  = result.last;

endmodule

// File: hdl/m4m_front.sv
module m4m_front #(
  parameter int MATRIX_DIM = 4
) (
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [m4m_pkg::INDEX_W-1:0]  elem_index_i,
  input  logic signed [m4m_pkg::ELEM_W-1:0] a_elem_i,
  input  logic signed [m4m_pkg::ELEM_W-1:0] b_elem_i,
  input  logic                         start_req_i,
  input  m4m_pkg::queue_status_t       q_status_i,
  output logic                         push_o,
  output m4m_pkg::cmd_t                cmd_o
);

  localparam int CELLS = MATRIX_DIM * MATRIX_DIM;

  logic in_range;

  // A position outside the matrix still carries its start request.
  assign in_range   = int'(elem_index_i) < CELLS;
  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  always_comb begin
    cmd_o.wr    = in_range;
    cmd_o.idx   = elem_index_i;
    cmd_o.a     = a_elem_i;
    cmd_o.b     = b_elem_i;
    cmd_o.start = start_req_i;
  end

endmodule

// File: hdl/m4m_queue.sv
module m4m_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  m4m_pkg::cmd_t          cmd_i,
  input  logic                   pop_i,
  output m4m_pkg::cmd_t          cmd_o,
  output m4m_pkg::queue_status_t status_o
);

  localparam int PTR_W = $clog2(m4m_pkg::QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  m4m_pkg::cmd_t    entry_q [m4m_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CNT_W'(m4m_pkg::QUEUE_DEPTH));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign cmd_o          = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: hdl/m4m_back.sv
module m4m_back #(
  parameter int MATRIX_DIM = 4,
  parameter int FRAC_BITS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  m4m_pkg::cmd_t          cmd_i,
  input  m4m_pkg::queue_status_t q_status_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output m4m_pkg::result_t       result_o
);

  localparam int CELLS = MATRIX_DIM * MATRIX_DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int KW    = $clog2(MATRIX_DIM);
  localparam int EW    = m4m_pkg::ELEM_W;
  localparam int PW    = m4m_pkg::PROD_W;
  localparam int ACC_W = PW + KW;
  localparam logic signed [ACC_W-1:0] POS_BOUND = ACC_W'(1) <<< (EW - 1 + FRAC_BITS);
  localparam logic signed [ACC_W-1:0] NEG_BOUND = -POS_BOUND;

  m4m_pkg::back_state_e state_q, state_d;

  logic [KW-1:0] k_q, k_d, r_q, r_d, c_q, c_d;
  logic [AW-1:0] p_q, p_d;
  logic          issue, load_out, out_free, wr_en;
  logic [AW-1:0] wr_addr, left_addr, right_addr;

  logic [EW-1:0] left_mem  [CELLS];
  logic [EW-1:0] right_mem [CELLS];
  logic [CELLS-1:0] written_q;

  logic                 rd_vld_q, rd_first_q, rd_last_q;
  logic                 left_ok_q, right_ok_q;
  logic [EW-1:0]        left_rd_q, right_rd_q;
  logic signed [EW-1:0] left_op, right_op;
  logic                 mul_vld_q, mul_first_q, mul_last_q;
  logic signed [PW-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q, acc_base, acc_shift;
  logic                 acc_done_q;

  logic [EW-1:0] sat_value;
  logic          sat_flag;

  assign wr_en      = pop_o && cmd_i.wr;
  assign wr_addr    = AW'(cmd_i.idx);
  assign left_addr  = AW'(int'(k_q) * MATRIX_DIM + int'(r_q));
  assign right_addr = AW'(int'(c_q) * MATRIX_DIM + int'(k_q));
  assign out_free   = !out_valid_o || !out_stall_i;

  // Sequencer: one multiply-accumulate per cycle, then one result word.
  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    r_d      = r_q;
    c_d      = c_q;
    p_d      = p_q;
    pop_o    = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      m4m_pkg::BK_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o = 1'b1;
          if (cmd_i.start) begin
            state_d = m4m_pkg::BK_ISSUE;
            k_d     = '0;
            r_d     = '0;
            c_d     = '0;
            p_d     = '0;
          end
        end
      end
      m4m_pkg::BK_ISSUE: begin
        issue = 1'b1;
        if (k_q == KW'(MATRIX_DIM - 1)) begin
          k_d     = '0;
          state_d = m4m_pkg::BK_DRAIN;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      m4m_pkg::BK_DRAIN: begin
        if (acc_done_q) begin
          state_d = m4m_pkg::BK_EMIT;
        end
      end
      m4m_pkg::BK_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (p_q == AW'(CELLS - 1)) begin
            state_d = m4m_pkg::BK_IDLE;
          end else begin
            state_d = m4m_pkg::BK_ISSUE;
            p_d     = p_q + AW'(1);
            if (r_q == KW'(MATRIX_DIM - 1)) begin
              r_d = '0;
              c_d = c_q + KW'(1);
            end else begin
              r_d = r_q + KW'(1);
            end
          end
        end
      end
      default: begin
        state_d = m4m_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= m4m_pkg::BK_IDLE;
      k_q     <= '0;
      r_q     <= '0;
      c_q     <= '0;
      p_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      r_q     <= r_d;
      c_q     <= c_d;
      p_q     <= p_d;
    end
  end

  // Element stores with registered reads.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      left_mem[wr_addr]  <= cmd_i.a;
      right_mem[wr_addr] <= cmd_i.b;
    end
    left_rd_q  <= left_mem[left_addr];
    right_rd_q <= right_mem[right_addr];
  end

  // An entry never written reads as zero, as after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q  <= '0;
      left_ok_q  <= 1'b0;
      right_ok_q <= 1'b0;
    end else begin
      if (wr_en) begin
        written_q[wr_addr] <= 1'b1;
      end
      left_ok_q  <= written_q[left_addr];
      right_ok_q <= written_q[right_addr];
    end
  end

  assign left_op  = left_ok_q  ? left_rd_q  : '0;
  assign right_op = right_ok_q ? right_rd_q : '0;
  assign acc_base = mul_first_q ? '0 : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      rd_first_q  <= 1'b0;
      rd_last_q   <= 1'b0;
      mul_vld_q   <= 1'b0;
      mul_first_q <= 1'b0;
      mul_last_q  <= 1'b0;
      acc_done_q  <= 1'b0;
    end else begin
      rd_vld_q    <= issue;
      rd_first_q  <= issue && (k_q == '0);
      rd_last_q   <= issue && (k_q == KW'(MATRIX_DIM - 1));
      mul_vld_q   <= rd_vld_q;
      mul_first_q <= rd_first_q;
      mul_last_q  <= rd_last_q;
      if (mul_vld_q && mul_last_q) begin
        acc_done_q <= 1'b1;
      end else if (load_out) begin
        acc_done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= left_op * right_op;
    if (mul_vld_q) begin
      acc_q <= acc_base + {{KW{prod_q[PW-1]}}, prod_q};
    end
  end

  // Drop the fraction bits toward minus infinity and clip to 32 bits.
  assign acc_shift = acc_q >>> FRAC_BITS;

  always_comb begin
    if (acc_q >= POS_BOUND) begin
      sat_value = m4m_pkg::ELEM_MAX;
      sat_flag  = 1'b1;
    end else if (acc_q < NEG_BOUND) begin
      sat_value = m4m_pkg::ELEM_MIN;
      sat_flag  = 1'b1;
    end else begin
      sat_value = acc_shift[EW-1:0];
      sat_flag  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load_out) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      result_o.index     <= m4m_pkg::INDEX_W'(p_q);
      result_o.value     <= sat_value;
      result_o.saturated <= sat_flag;
      result_o.last      <= (p_q == AW'(CELLS - 1));
    end
  end

endmodule

// File: hdl/m4m_checker.sv
module m4m_checker #(
  parameter int MATRIX_DIM = 4
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_i,
  input logic                              out_stall_i,
  input logic [m4m_pkg::INDEX_W-1:0]       out_index_i,
  input logic [m4m_pkg::ELEM_W-1:0]        out_value_i,
  input logic                              saturated_i,
  input logic                              out_last_i
);

  localparam logic [m4m_pkg::INDEX_W-1:0] LAST_INDEX =
    m4m_pkg::INDEX_W'(MATRIX_DIM * MATRIX_DIM - 1);

  // A stalled result word stays offered.
  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result word withdrawn while stalled");

  // A stalled result word keeps its value.
  a_out_value_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(out_value_i) && $stable(out_index_i))
    else $error("result word changed while stalled");

  // A clipped element carries one of the two range limits.
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i |->
      out_value_i == m4m_pkg::ELEM_MAX || out_value_i == m4m_pkg::ELEM_MIN)
    else $error("saturated element not at a range limit");

  // The final element of a product is the last matrix position.
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i |-> out_index_i == LAST_INDEX)
    else $error("last flag on the wrong position");

endmodule

bind matrix4x4_multiply_top m4m_checker #(
  .MATRIX_DIM(MATRIX_DIM)
) u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_index_i(out_index_o),
  .out_value_i(out_value_o),
  .saturated_i(saturated_o),
  .out_last_i (out_last_o)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int DIM   = 4;
  localparam int FRAC  = 16;
  localparam int CELLS = DIM * DIM;

  localparam int INDEX_W = m4m_pkg::INDEX_W;
  localparam int ELEM_W  = m4m_pkg::ELEM_W;
  localparam logic [ELEM_W-1:0] ELEM_MAX = m4m_pkg::ELEM_MAX;
  localparam logic [ELEM_W-1:0] ELEM_MIN = m4m_pkg::ELEM_MIN;

  typedef m4m_pkg::result_t result_t;

  // The exact sum of four 32 by 32 products needs 66 bits; keep some margin.
  localparam int SUM_W = 72;
  localparam logic signed [SUM_W-1:0] SUM_BOUND = SUM_W'(1) <<< (31 + FRAC);

  // Cycles without any accepted word before the run is declared hung. The
  // worst honest gap is the long output hold-off below.
  localparam int HANG_LIMIT    = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER    = 40;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_WORDS  = 150;

  typedef enum int {
    VAL_SMALL,
    VAL_ANY,
    VAL_EDGE
  } value_mode_e;

  // One input word as it is offered to the block.
  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [ELEM_W-1:0]  a;
    logic [ELEM_W-1:0]  b;
    logic               start;
  } elem_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                       in_valid_i   = 1'b0;
  logic                       in_stall_o;
  logic [INDEX_W-1:0]         elem_index_i = '0;
  logic signed [ELEM_W-1:0]   a_elem_i     = '0;
  logic signed [ELEM_W-1:0]   b_elem_i     = '0;
  logic                       start_req_i  = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i  = 1'b0;
  logic [INDEX_W-1:0]         out_index_o;
  logic signed [ELEM_W-1:0]   out_value_o;
  logic                       saturated_o;
  logic                       out_last_o;

  matrix4x4_multiply_top #(
    .MATRIX_DIM (DIM),
    .FRAC_BITS  (FRAC)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .elem_index_i (elem_index_i),
    .a_elem_i     (a_elem_i),
    .b_elem_i     (b_elem_i),
    .start_req_i  (start_req_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_index_o  (out_index_o),
    .out_value_o  (out_value_o),
    .saturated_o  (saturated_o),
    .out_last_o   (out_last_o)
  );

  // Words waiting to be offered, and product words the block still owes us.
  elem_word_t pending_words[$];
  result_t    product_words_due[$];

  // Our own copy of the two element stores; both read as zero after reset.
  logic signed [ELEM_W-1:0] left_elems[CELLS]  = '{default: '0};
  logic signed [ELEM_W-1:0] right_elems[CELLS] = '{default: '0};

  int   mismatches  = 0;
  int   words_taken = 0;
  int   cycle_no    = 0;
  int   idle_cycles = 0;
  logic word_taken  = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Prints one line per mismatch and keeps the count for the final verdict.
  task automatic report_mismatch(string what, logic [ELEM_W-1:0] got,
                                 logic [ELEM_W-1:0] want);
    $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Works out every element of C = A * B from the current stores and queues
  // them in column-major order. The sum is exact, then either clipped or
  // shifted right arithmetically, which rounds toward minus infinity.
  function automatic void push_product_words();
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] lhs;
    logic signed [SUM_W-1:0] rhs;
    logic signed [SUM_W-1:0] shifted;
    result_t                 word;
    for (int c = 0; c < DIM; c++) begin
      for (int r = 0; r < DIM; r++) begin
        acc = '0;
        for (int k = 0; k < DIM; k++) begin
          lhs = left_elems[k * DIM + r];
          rhs = right_elems[c * DIM + k];
          acc += lhs * rhs;
        end
        word.index = INDEX_W'(c * DIM + r);
        word.last  = (c * DIM + r == CELLS - 1);
        if (acc >= SUM_BOUND) begin
          word.value     = ELEM_MAX;
          word.saturated = 1'b1;
        end else if (acc < -SUM_BOUND) begin
          word.value     = ELEM_MIN;
          word.saturated = 1'b1;
        end else begin
          shifted        = acc >>> FRAC;
          word.value     = shifted[ELEM_W-1:0];
          word.saturated = 1'b0;
        end
        product_words_due.push_back(word);
      end
    end
  endfunction

  task automatic add_word(int idx, logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b,
                          logic start);
    elem_word_t w;
    w.idx   = INDEX_W'(idx);
    w.a     = a;
    w.b     = b;
    w.start = start;
    pending_words.push_back(w);
  endtask

  // Small values stay clear of the limits, edge values hit them hard, and
  // fully random values toggle every bit and saturate often.
  function automatic logic [ELEM_W-1:0] pick_element(value_mode_e mode);
    int small_val;
    case (mode)
      VAL_SMALL: begin
        small_val = int'($urandom_range(0, 2**19)) - 2**18;
        return ELEM_W'(small_val);
      end
      VAL_ANY: return $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0:       return ELEM_MIN;
          1:       return ELEM_MAX;
          2:       return '0;
          3:       return '1;
          4:       return 32'h0001_0000;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // A quarter of the time both sides run flat out, with no gaps at all.
  function automatic logic calm_phase();
    return (cycle_no % 1600) >= 1200;
  endfunction

  // Input side monitor and predictor, plus the result checker. Both sample
  // at the rising edge, when the handshake is decided.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      word_taken = in_valid_i && !in_stall_o;
      if (word_taken) begin
        words_taken++;
        // Every 4-bit index lands inside a 4x4 matrix, so each word writes.
        if (elem_index_i < CELLS) begin
          left_elems[elem_index_i]  = a_elem_i;
          right_elems[elem_index_i] = b_elem_i;
        end
        if (start_req_i) push_product_words();
      end
      if (out_valid_o && !out_stall_i) begin
        if (product_words_due.size() == 0) begin
          report_mismatch("result word with nothing due, index",
                          ELEM_W'(out_index_o), '0);
        end else begin
          result_t due;
          due = product_words_due.pop_front();
          if (out_index_o !== due.index)
            report_mismatch("out_index", ELEM_W'(out_index_o), ELEM_W'(due.index));
          if (out_value_o !== due.value)
            report_mismatch("out_value", out_value_o, due.value);
          if (saturated_o !== due.saturated)
            report_mismatch("saturated", ELEM_W'(saturated_o), ELEM_W'(due.saturated));
          if (out_last_o !== due.last)
            report_mismatch("out_last", ELEM_W'(out_last_o), ELEM_W'(due.last));
        end
      end
    end
  end

  // Driver: a new word goes out at the falling edge once the previous one
  // has been taken, so a stalled payload is held exactly as it was.
  int send_gap = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (word_taken || !in_valid_i)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() > 0) begin
        elem_word_t w;
        w = pending_words.pop_front();
        elem_index_i <= w.idx;
        a_elem_i     <= w.a;
        b_elem_i     <= w.b;
        start_req_i  <= w.start;
        in_valid_i   <= 1'b1;
        send_gap     = calm_phase() ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side stall. Once, some way into the run, the receiver holds off
  // for a long stretch while the driver keeps offering words, so the block's
  // command queue fills up and it has to stall its own input.
  int   stall_left    = 0;
  int   hold_left     = 0;
  logic pressure_done = 1'b0;

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!pressure_done && words_taken >= HOLD_AFTER) begin
      pressure_done = 1'b1;
      hold_left     = HOLD_CYCLES;
      out_stall_i   <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (!calm_phase()) stall_left = pick_gap();
    end
  end

  // Watchdog: ends the run if neither side moves a word for too long.
  always @(posedge clk_i) begin
    cycle_no++;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("ERROR %0t: no word moved for %0d cycles", $realtime, HANG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int          order[CELLS];
    int          tmp;
    int          pick;
    int          burst;
    value_mode_e mode;

    // Directed words first. The very first start multiplies the stores
    // straight out of reset, which must give an all-zero product.
    add_word(0, '0, '0, 1'b1);

    // Identity-scaled diagonal for A, a mix of values on B's diagonal,
    // including both extremes.
    add_word(0,  32'h0001_0000, 32'h0002_8000, 1'b0);
    add_word(5,  32'h0001_0000, 32'hFFFE_0000, 1'b0);
    add_word(10, 32'h0001_0000, ELEM_MAX,      1'b0);
    add_word(15, 32'h0001_0000, ELEM_MIN,      1'b1);

    // Only diagonals are set now, so the top-left element of C is just
    // A00 * B00. Drive it past the top and the bottom of the range.
    add_word(0, ELEM_MIN, ELEM_MIN, 1'b1);
    add_word(0, ELEM_MIN, ELEM_MAX, 1'b1);
    add_word(0, ELEM_MAX, ELEM_MAX, 1'b1);

    // A tiny negative product must round down to minus one LSB.
    add_word(0, '1, 32'h0000_0001, 1'b1);

    // Exactly 2^47 clips high; exactly -2^47 is the most negative value
    // that still fits and must not be flagged.
    add_word(0, 32'h0100_0000, 32'h0080_0000, 1'b1);
    add_word(0, 32'hFF00_0000, 32'h0080_0000, 1'b1);

    // Two large terms in one sum, then a plain write to the last index.
    add_word(4, ELEM_MAX, 32'h0000_0003, 1'b0);
    add_word(1, 32'h0000_0005, ELEM_MIN, 1'b1);
    add_word(15, ELEM_MIN, ELEM_MAX, 1'b0);

    // Random part: mostly complete matrices written in shuffled order with
    // the start on the final word, plus short bursts of stray writes that
    // only sometimes end in a start.
    while (pending_words.size() < RANDOM_WORDS) begin
      if ($urandom_range(0, 3) != 0) begin
        mode = value_mode_e'($urandom_range(0, 2));
        for (int i = 0; i < CELLS; i++) order[i] = i;
        for (int i = CELLS - 1; i > 0; i--) begin
          pick        = $urandom_range(0, i);
          tmp         = order[i];
          order[i]    = order[pick];
          order[pick] = tmp;
        end
        for (int i = 0; i < CELLS; i++)
          add_word(order[i], pick_element(mode), pick_element(mode), i == CELLS - 1);
      end else begin
        burst = $urandom_range(1, 4);
        for (int i = 0; i < burst; i++)
          add_word($urandom_range(0, CELLS - 1), pick_element(VAL_ANY),
                   pick_element(VAL_ANY), (i == burst - 1) && ($urandom_range(0, 1) == 1));
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for the last word to be taken, then for every owed product word,
    // then a little longer to catch anything the block emits uninvited.
    while (pending_words.size() > 0 || in_valid_i) @(posedge clk_i);
    while (product_words_due.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
